// ----- hdl/ikpbd_pkg.sv -----
// Shared types and constants for the IK pole bend direction unit.
// Used by ikpbd_normalize and ik_pole_bend_direction_unit; no dependencies.
`default_nettype none

package ikpbd_pkg;

  // Signed width of a vector component entering the normalizer.
  localparam int VEC_W      = 36;
  // Width of a normalized magnitude; the largest one lands in [2^30, 2^31).
  localparam int MAG_W      = 31;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;
  // Front stages (magnitude, align, square) plus the sum stage, root and divide.
  localparam int NORM_LAT   = 3 + (SQRT_STEPS + 1) + DIV_STEPS;

  localparam logic [31:0] THRESH_RESET = 32'd4295;

  typedef logic signed [VEC_W-1:0] vin_t;
  typedef logic signed [31:0]      dir_t;

  typedef enum logic [1:0] {
    PATH_JOINT = 2'd0,
    PATH_UP    = 2'd1,
    PATH_RIGHT = 2'd2,
    PATH_ZERO  = 2'd3
  } path_t;

  typedef struct packed {
    logic valid;
    logic zero;
  } norm_stat_t;

  typedef struct packed {
    logic [63:0] n;
    logic [63:0] r;
  } sqrt_st_t;

  function automatic logic [VEC_W-1:0] vin_mag(vin_t v);
    logic [VEC_W-1:0] u;
    u = v;
    return v[VEC_W-1] ? (~u + 1'b1) : u;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/ikpbd_normalize.sv -----
// Pipelined 3-vector normalizer: align, sum of squares, bit-per-stage
// integer square root and bit-per-stage restoring divide. Uses ikpbd_pkg.
`default_nettype none

module ikpbd_normalize (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  ikpbd_pkg::vin_t         in_vec [3],
  output ikpbd_pkg::norm_stat_t   out_stat,
  output ikpbd_pkg::dir_t         out_vec [3]
);
  import ikpbd_pkg::*;

  localparam int POS_W = $clog2(VEC_W);
  localparam int REM_W = 34;

  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, int k);
    logic [63:0] bitv;
    logic [63:0] t;
    sqrt_st_t    o;
    bitv = 64'd1 << (62 - 2 * k);
    t    = s.r + bitv;
    if (s.n >= t) begin
      o.n = s.n - t;
      o.r = (s.r >> 1) + bitv;
    end else begin
      o.n = s.n;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  // Returns {quotient bit, new remainder}.
  function automatic logic [REM_W:0] div_step(logic [REM_W-1:0] rem, logic [31:0] l,
                                               logic shift);
    logic [REM_W-1:0] t;
    logic [REM_W-1:0] le;
    t  = shift ? (rem << 1) : rem;
    le = {{(REM_W-32){1'b0}}, l};
    if (t >= le) return {1'b1, t - le};
    else return {1'b0, t};
  endfunction

  logic [NORM_LAT-1:0] vld_r;

  logic [VEC_W-1:0] m1_r [3];
  logic [VEC_W-1:0] mx1_r;
  logic [2:0]       neg1_r;

  logic [MAG_W-1:0] m2_r [3];
  logic [2:0]       neg2_r;
  logic             zero2_r;

  logic [2*MAG_W-1:0] sq3_r [3];
  logic [MAG_W-1:0]   m3_r [3];
  logic [2:0]         neg3_r;
  logic               zero3_r;

  sqrt_st_t         sq_st_r   [SQRT_STEPS+1];
  logic [MAG_W-1:0] sq_m_r    [SQRT_STEPS+1][3];
  logic [2:0]       sq_neg_r  [SQRT_STEPS+1];
  logic             sq_zero_r [SQRT_STEPS+1];

  logic [REM_W-1:0] dv_rem_r  [DIV_STEPS][3];
  logic [MAG_W-1:0] dv_q_r    [DIV_STEPS][3];
  logic [31:0]      dv_l_r    [DIV_STEPS];
  logic [2:0]       dv_neg_r  [DIV_STEPS];
  logic             dv_zero_r [DIV_STEPS];

  logic [VEC_W-1:0] mag_in [3];
  logic [VEC_W-1:0] mx_in;
  logic [POS_W-1:0] pos;
  logic [VEC_W-1:0] shifted [3];

  always_comb begin
    for (int i = 0; i < 3; i++) mag_in[i] = vin_mag(in_vec[i]);
    mx_in = mag_in[0];
    if (mag_in[1] > mx_in) mx_in = mag_in[1];
    if (mag_in[2] > mx_in) mx_in = mag_in[2];
  end

  // Position of the leading one of the largest magnitude sets a common shift.
  always_comb begin
    pos = '0;
    for (int i = 0; i < VEC_W; i++) begin
      if (mx1_r[i]) pos = POS_W'(i);
    end
    for (int i = 0; i < 3; i++) begin
      if (pos > POS_W'(MAG_W - 1)) shifted[i] = m1_r[i] >> (pos - POS_W'(MAG_W - 1));
      else shifted[i] = m1_r[i] << (POS_W'(MAG_W - 1) - pos);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NORM_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    logic [REM_W:0] ds;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m1_r[i]   <= mag_in[i];
        neg1_r[i] <= in_vec[i][VEC_W-1];
        m2_r[i]   <= shifted[i][MAG_W-1:0];
        sq3_r[i]  <= m2_r[i] * m2_r[i];
        m3_r[i]   <= m2_r[i];
      end
      mx1_r   <= mx_in;
      neg2_r  <= neg1_r;
      zero2_r <= (mx1_r == '0);
      neg3_r  <= neg2_r;
      zero3_r <= zero2_r;

      sq_st_r[0].n <= {2'b00, sq3_r[0]} + {2'b00, sq3_r[1]} + {2'b00, sq3_r[2]};
      sq_st_r[0].r <= '0;
      sq_m_r[0]    <= m3_r;
      sq_neg_r[0]  <= neg3_r;
      sq_zero_r[0] <= zero3_r;
      for (int k = 1; k <= SQRT_STEPS; k++) begin
        sq_st_r[k]   <= sqrt_step(sq_st_r[k-1], k - 1);
        sq_m_r[k]    <= sq_m_r[k-1];
        sq_neg_r[k]  <= sq_neg_r[k-1];
        sq_zero_r[k] <= sq_zero_r[k-1];
      end

      for (int i = 0; i < 3; i++) begin
        ds = div_step({{(REM_W-MAG_W){1'b0}}, sq_m_r[SQRT_STEPS][i]},
                      sq_st_r[SQRT_STEPS].r[31:0], 1'b0);
        dv_rem_r[0][i] <= ds[REM_W-1:0];
        dv_q_r[0][i]   <= {{(MAG_W-1){1'b0}}, ds[REM_W]};
      end
      dv_l_r[0]    <= sq_st_r[SQRT_STEPS].r[31:0];
      dv_neg_r[0]  <= sq_neg_r[SQRT_STEPS];
      dv_zero_r[0] <= sq_zero_r[SQRT_STEPS];
      for (int j = 1; j < DIV_STEPS; j++) begin
        for (int i = 0; i < 3; i++) begin
          ds = div_step(dv_rem_r[j-1][i], dv_l_r[j-1], 1'b1);
          dv_rem_r[j][i] <= ds[REM_W-1:0];
          dv_q_r[j][i]   <= {dv_q_r[j-1][i][MAG_W-2:0], ds[REM_W]};
        end
        dv_l_r[j]    <= dv_l_r[j-1];
        dv_neg_r[j]  <= dv_neg_r[j-1];
        dv_zero_r[j] <= dv_zero_r[j-1];
      end
    end
  end

  always_comb begin
    out_stat.valid = vld_r[NORM_LAT-1];
    out_stat.zero  = dv_zero_r[DIV_STEPS-1];
    for (int i = 0; i < 3; i++) begin
      if (dv_zero_r[DIV_STEPS-1]) out_vec[i] = '0;
      else if (dv_neg_r[DIV_STEPS-1][i]) out_vec[i] = -$signed({1'b0, dv_q_r[DIV_STEPS-1][i]});
      else out_vec[i] = $signed({1'b0, dv_q_r[DIV_STEPS-1][i]});
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ik_pole_bend_direction_unit.sv -----
// Two-bone IK bend direction: axis normalize, offset projection, fallback
// selection and final normalize. Uses ikpbd_pkg and ikpbd_normalize.
// Throughput: one item per cycle; a stalled output freezes the whole pipeline.
// Reset clears all valid bits and loads the threshold with 4295.
`default_nettype none

module ik_pole_bend_direction_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // root_x, root_y, root_z, mid_x, mid_y, mid_z, end_x, end_y, end_z (lowest first)
  input  logic [287:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // dir_x, dir_y, dir_z (lowest first)
  output logic [95:0]  out_tdata,
  // path_taken
  output logic [1:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);
  import ikpbd_pkg::*;

  localparam int DOT_W = 38;

  function automatic logic [DOT_W-1:0] dot_mag(logic signed [DOT_W-1:0] v);
    logic [DOT_W-1:0] u;
    u = v;
    return v[DOT_W-1] ? (~u + 1'b1) : u;
  endfunction

  function automatic logic [MAG_W-1:0] dir_mag(dir_t v);
    logic [31:0] u;
    u = v[31] ? (~v + 1'b1) : v;
    return u[MAG_W-1:0];
  endfunction

  logic en;
  logic [31:0] thresh_r;

  logic va_r;
  vin_t d_r [3];
  vin_t b_r [3];

  norm_stat_t n1_stat;
  dir_t       a_n [3];
  vin_t       b_dl_r [NORM_LAT][3];

  logic [7:1] tv_r;
  vin_t b1_r [3], b2_r [3], b3_r [3];
  dir_t a1_r [3], a2_r [3], a3_r [3], a4_r [3], a5_r [3], a6_r [3];
  vin_t term1_r [3];
  logic signed [DOT_W-1:0] dot2_r;
  logic signed [DOT_W-1:0] pd3_r [3];
  logic signed [DOT_W-1:0] p4_r [3];
  vin_t p5_r [3], p6_r [3];
  logic [2*MAG_W-1:0] sqp5_r [3];
  logic [2*MAG_W-1:0] sqa5_r [2];
  logic big5_r;
  logic small_p6_r, small_a6_r;
  vin_t  cand7_r [3];
  path_t path7_r;

  norm_stat_t n2_stat;
  dir_t       u_n [3];
  path_t      path_dl_r [NORM_LAT];

  logic  out_valid_r;
  dir_t  dir_r [3];
  path_t path_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_valid) begin
      thresh_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      tv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      va_r        <= in_tvalid;
      tv_r        <= {tv_r[6:1], n1_stat.valid};
      out_valid_r <= n2_stat.valid;
    end
  end

  ikpbd_normalize u_axis (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (va_r),
    .in_vec   (d_r),
    .out_stat (n1_stat),
    .out_vec  (a_n)
  );

  ikpbd_normalize u_dir (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (tv_r[7]),
    .in_vec   (cand7_r),
    .out_stat (n2_stat),
    .out_vec  (u_n)
  );

  always_ff @(posedge clk) begin
    vin_t               r, m, e;
    logic [VEC_W+MAG_W-1:0] pr;
    logic [DOT_W+MAG_W-1:0] pq;
    logic [DOT_W-1:0]   pm;
    logic               bg;
    logic [63:0]        sp;
    logic [63:0]        sa;
    if (en) begin
      // Input stage: chain axis and doubled offset from the midpoint.
      for (int i = 0; i < 3; i++) begin
        r = vin_t'($signed(in_tdata[32*i +: 32]));
        m = vin_t'($signed(in_tdata[32*(3+i) +: 32]));
        e = vin_t'($signed(in_tdata[32*(6+i) +: 32]));
        d_r[i] <= e - r;
        b_r[i] <= (m <<< 1) - r - e;
      end

      b_dl_r[0] <= b_r;
      for (int k = 1; k < NORM_LAT; k++) b_dl_r[k] <= b_dl_r[k-1];

      // Per-term dot product, each term truncated toward zero.
      for (int i = 0; i < 3; i++) begin
        pr = vin_mag(b_dl_r[NORM_LAT-1][i]) * dir_mag(a_n[i]);
        if (b_dl_r[NORM_LAT-1][i][VEC_W-1] ^ a_n[i][31])
          term1_r[i] <= -$signed(pr[30 +: VEC_W]);
        else
          term1_r[i] <= $signed(pr[30 +: VEC_W]);
      end
      b1_r <= b_dl_r[NORM_LAT-1];
      a1_r <= a_n;

      dot2_r <= DOT_W'(term1_r[0]) + DOT_W'(term1_r[1]) + DOT_W'(term1_r[2]);
      b2_r   <= b1_r;
      a2_r   <= a1_r;

      for (int i = 0; i < 3; i++) begin
        pq = dot_mag(dot2_r) * dir_mag(a2_r[i]);
        if (dot2_r[DOT_W-1] ^ a2_r[i][31]) pd3_r[i] <= -$signed(pq[30 +: DOT_W]);
        else pd3_r[i] <= $signed(pq[30 +: DOT_W]);
      end
      b3_r <= b2_r;
      a3_r <= a2_r;

      for (int i = 0; i < 3; i++) p4_r[i] <= DOT_W'(b3_r[i]) - pd3_r[i];
      a4_r <= a3_r;

      bg = 1'b0;
      for (int i = 0; i < 3; i++) begin
        pm = dot_mag(p4_r[i]);
        if (|pm[DOT_W-1:MAG_W]) bg = 1'b1;
        sqp5_r[i] <= pm[MAG_W-1:0] * pm[MAG_W-1:0];
        p5_r[i]   <= p4_r[i][VEC_W-1:0];
      end
      big5_r    <= bg;
      sqa5_r[0] <= dir_mag(a4_r[0]) * dir_mag(a4_r[0]);
      sqa5_r[1] <= dir_mag(a4_r[2]) * dir_mag(a4_r[2]);
      a5_r      <= a4_r;

      sp = {2'b00, sqp5_r[0]} + {2'b00, sqp5_r[1]} + {2'b00, sqp5_r[2]};
      sa = {2'b00, sqa5_r[0]} + {2'b00, sqa5_r[1]};
      small_p6_r <= !big5_r && (sp < {30'd0, thresh_r, 2'b00});
      small_a6_r <= sa < {4'd0, thresh_r, 28'd0};
      p6_r <= p5_r;
      a6_r <= a5_r;

      // Fallbacks are axis x up, then axis x right.
      if (!small_p6_r) begin
        cand7_r <= p6_r;
        path7_r <= PATH_JOINT;
      end else if (small_a6_r) begin
        cand7_r[0] <= '0;
        cand7_r[1] <= vin_t'(a6_r[2]);
        cand7_r[2] <= -vin_t'(a6_r[1]);
        path7_r    <= PATH_RIGHT;
      end else begin
        cand7_r[0] <= -vin_t'(a6_r[2]);
        cand7_r[1] <= '0;
        cand7_r[2] <= vin_t'(a6_r[0]);
        path7_r    <= PATH_UP;
      end

      path_dl_r[0] <= path7_r;
      for (int k = 1; k < NORM_LAT; k++) path_dl_r[k] <= path_dl_r[k-1];

      dir_r  <= u_n;
      path_r <= n2_stat.zero ? PATH_ZERO : path_dl_r[NORM_LAT-1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {dir_r[2], dir_r[1], dir_r[0]};
  assign out_tuser  = path_r;

endmodule

`default_nettype wire

// ----- bench/ik_pole_bend_direction_unit_tb.sv -----
// Self-checking bench for ik_pole_bend_direction_unit: random and directed joint
// triples are streamed in, bend directions are predicted here and compared on output.
// Depends on ikpbd_pkg and the unit's RTL.
`timescale 1ns / 100ps

module ik_pole_bend_direction_unit_tb;
  import ikpbd_pkg::*;

  localparam int LATENCY   = 142;
  localparam int WDOG_MAX  = 20000;

  typedef struct packed {
    logic [31:0] ez, ey, ex, mz, my, mx, rz, ry, rx;
  } joints_t;

  typedef struct {
    logic [31:0] dx, dy, dz;
    path_t       path;
  } bend_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [287:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [31:0]  cfg_data;

  ik_pole_bend_direction_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  joints_t     pending_q[$];
  bend_t       bend_q[$];
  logic [31:0] thresh;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          mismatches;
  int          n_checked;
  int          n_path[4];
  int          idle_cycles;
  bit          timed_out;
  bit          in_taken;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned amag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint qmul(longint x, longint y);
    longint unsigned p;
    p = (amag(x) * amag(y)) >> 30;
    return ((x < 0) != (y < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Returns 0 for the zero vector, leaving u at zero.
  function automatic bit unit_vec(input longint v[3], output longint u[3]);
    longint unsigned m[3], mx, l2, len;
    mx = 0;
    l2 = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = amag(v[i]);
      u[i] = 0;
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return 0;
    while (mx >= (64'd1 << 31)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 30)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) l2 += m[i] * m[i];
    len = int_sqrt(l2);
    for (int i = 0; i < 3; i++) begin
      u[i] = longint'((m[i] << 30) / len);
      if (v[i] < 0) u[i] = -u[i];
    end
    return 1;
  endfunction

  function automatic bend_t bend_dir(joints_t j, logic [31:0] th);
    longint r[3], md[3], e[3], d[3], a[3], b[3], p[3], c[3], u[3];
    longint dot;
    longint unsigned s;
    bit big;
    path_t path;
    bend_t res;
    r  = '{longint'(signed'(j.rx)), longint'(signed'(j.ry)), longint'(signed'(j.rz))};
    md = '{longint'(signed'(j.mx)), longint'(signed'(j.my)), longint'(signed'(j.mz))};
    e  = '{longint'(signed'(j.ex)), longint'(signed'(j.ey)), longint'(signed'(j.ez))};
    for (int i = 0; i < 3; i++) begin
      d[i] = e[i] - r[i];
      b[i] = 2 * md[i] - r[i] - e[i];
    end
    void'(unit_vec(d, a));
    dot = 0;
    for (int i = 0; i < 3; i++) dot += qmul(b[i], a[i]);
    big = 0;
    for (int i = 0; i < 3; i++) begin
      p[i] = b[i] - qmul(dot, a[i]);
      if (amag(p[i]) >= (64'd1 << 31)) big = 1;
    end
    path = PATH_JOINT;
    if (!big) begin
      s = 0;
      for (int i = 0; i < 3; i++) s += amag(p[i]) * amag(p[i]);
      if (s < longint'(th) * 4) path = PATH_UP;
    end
    if (path == PATH_JOINT) begin
      c = p;
    end else begin
      s = amag(a[0]) * amag(a[0]) + amag(a[2]) * amag(a[2]);
      if (s < (longint'(th) << 28)) begin
        path = PATH_RIGHT;
        c = '{0, a[2], -a[1]};
      end else begin
        c = '{-a[2], 0, a[0]};
      end
    end
    if (!unit_vec(c, u)) path = PATH_ZERO;
    res.dx = u[0][31:0];
    res.dy = u[1][31:0];
    res.dz = u[2][31:0];
    res.path = path;
    return res;
  endfunction

  // Input transfers are taken at the rising edge; the accepted item leaves the queue there.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      bend_q.push_back(bend_dir(joints_t'(in_tdata), thresh));
      void'(pending_q.pop_front());
      in_taken = 1'b1;
    end
  end

  // Driver: inputs change on the falling edge; an offered item is held until taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (!in_tvalid || in_taken) begin
        if (pending_q.size() > 0 && ($urandom_range(99) >= send_idle_pct)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_q[0];
        end else begin
          in_tvalid <= 1'b0;
          in_tdata  <= {9{$urandom}};
        end
      end
      in_taken = 1'b0;
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: sampled at the rising edge.
  always @(posedge clk) begin
    bend_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (bend_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with nothing expected: %h %0d",
                                       out_tdata, out_tuser);
      end else begin
        want = bend_q.pop_front();
        n_checked++;
        n_path[want.path]++;
        if (out_tdata[31:0] !== want.dx || out_tdata[63:32] !== want.dy ||
            out_tdata[95:64] !== want.dz || out_tuser !== want.path) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: exp %h %h %h path %0d, got %h %h %h path %0d",
                     want.dx, want.dy, want.dz, want.path,
                     out_tdata[31:0], out_tdata[63:32], out_tdata[95:64], out_tuser);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer while items are still outstanding.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || (pending_q.size() == 0 && bend_q.size() == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_MAX && !timed_out) begin
      timed_out = 1;
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic drain();
    while (pending_q.size() != 0 || in_tvalid) @(posedge clk);
    while (bend_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_thresh(logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    thresh = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rnd_coord(int kind);
    case (kind)
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< $urandom_range(16);
      default: return 32'($signed($urandom_range(200)) - 100);
    endcase
  endfunction

  // Bent chains mostly, with collinear and near-degenerate ones mixed in.
  function automatic joints_t rnd_joints();
    joints_t j;
    int kind, shape;
    kind  = $urandom_range(2);
    shape = $urandom_range(9);
    j.rx = rnd_coord(kind); j.ry = rnd_coord(kind); j.rz = rnd_coord(kind);
    j.ex = rnd_coord(kind); j.ey = rnd_coord(kind); j.ez = rnd_coord(kind);
    j.mx = rnd_coord(kind); j.my = rnd_coord(kind); j.mz = rnd_coord(kind);
    if (shape == 0) begin
      // middle joint on the midpoint: offset vanishes
      j.mx = (signed'(j.rx) + signed'(j.ex)) >>> 1;
      j.my = (signed'(j.ry) + signed'(j.ey)) >>> 1;
      j.mz = (signed'(j.rz) + signed'(j.ez)) >>> 1;
    end else if (shape == 1) begin
      j.ex = j.rx; j.ey = j.ry; j.ez = j.rz;
    end else if (shape == 2) begin
      // axis along y, so the up fallback is short
      j.ex = j.rx; j.ez = j.rz;
      j.mx = j.rx; j.mz = j.rz;
    end
    return j;
  endfunction

  task automatic run_items(int n, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) pending_q.push_back(rnd_joints());
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    joints_t j;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    thresh = THRESH_RESET;
    send_idle_pct = 29;
    recv_idle_pct = 46;
    mismatches = 0;
    n_checked = 0;
    n_path = '{0, 0, 0, 0};
    idle_cycles = 0;
    timed_out = 0;
    in_taken = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, coincident joints, collinear chains, axis along y.
    pending_q.push_back('0);
    pending_q.push_back({9{32'h7fffffff}});
    pending_q.push_back({9{32'h80000000}});
    j = '0; j.ex = 32'h80000000; j.mx = 32'h7fffffff; j.rx = 32'h7fffffff;
    pending_q.push_back(j);
    j = '0; j.ey = 32'h7fffffff; j.ry = 32'h80000000; j.mx = 32'h7fffffff;
    j.mz = 32'h80000000; pending_q.push_back(j);
    j = '0; j.ey = 32'h00010000; j.my = 32'h00008000; pending_q.push_back(j);
    j = '0; j.ex = 32'h00010000; j.mx = 32'h00008000; pending_q.push_back(j);
    j = '0; j.mx = 32'h00000001; pending_q.push_back(j);
    j = '0; j.ez = 32'h00030000; j.my = 32'h00020000; pending_q.push_back(j);
    j = '0; j.ex = 32'hffffffff; j.ey = 32'h1; j.ez = 32'hffffffff; j.mz = 32'h1;
    pending_q.push_back(j);
    for (int i = 0; i < 8; i++) pending_q.push_back({9{$urandom}});
    drain();

    write_thresh(32'd0);
    pending_q.push_back('0);
    j = '0; j.ex = 32'h00010000; j.mx = 32'h00008000; pending_q.push_back(j);
    j = '0; j.ex = 32'h00010000; j.my = 32'h1; pending_q.push_back(j);
    run_items(200, 29, 46);
    drain();

    write_thresh(32'hffffffff);
    run_items(300, 29, 46);
    drain();

    write_thresh(32'h00100000);
    run_items(400, 46, 29);
    drain();

    write_thresh(32'(THRESH_RESET));
    run_items(300, 46, 29);
    // Hold off until the pipeline has emptied, then stream without gaps.
    drain();
    write_thresh($urandom_range(32'h0fffffff));
    run_items(330, 0, 0);
    drain();

    $display("Checked %0d bend directions over six threshold settings.", n_checked);
    $display("Paths: joint %0d, up %0d, right %0d, zero %0d.",
             n_path[0], n_path[1], n_path[2], n_path[3]);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
